// ===== sv/brrb_pkg.sv =====
// ----------------------------------------------------------------------------
// brrb_pkg
// Shared types and constants for the bit-row raster blit.
// ----------------------------------------------------------------------------
package brrb_pkg;

  localparam int WORD_BITS        = 32;
  localparam int OFF_W            = 5;   // bit offset within a word
  localparam int IDX_W            = 7;   // word index within a row
  localparam int GPOS_W           = IDX_W + OFF_W;
  localparam int SEL_W            = OFF_W + 1;  // bit select in the mask pair
  localparam int ROP_W            = 3;
  localparam int SHIFT_W          = 14;
  localparam int ROWLEN_W         = 13;
  localparam int MODE_W           = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 14;
  localparam int DEF_MAX_ROW_BITS = 4096;

  localparam logic [ROWLEN_W-1:0] RST_ROW_BITS = ROWLEN_W'(4096);

  typedef enum logic [ROP_W-1:0] {
    ROP_SET    = 3'd0,
    ROP_SETNOT = 3'd1,
    ROP_AND    = 3'd2,
    ROP_OR     = 3'd3,
    ROP_ANDNOT = 3'd4,
    ROP_ORNOT  = 3'd5
  } rop_t;

  typedef enum logic [MODE_W-1:0] {
    BND_KEEP  = 2'd0,
    BND_CLEAR = 2'd1,
    BND_SET   = 2'd2
  } bnd_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RASTER_OP     = 3'd0,
    CFG_BIT_SHIFT     = 3'd1,
    CFG_DEST_ROW_BITS = 3'd2,
    CFG_MASK_ROW_BITS = 3'd3,
    CFG_BOUNDARY_MODE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] dest_word;
    logic [WORD_BITS-1:0] mask_low;
    logic [WORD_BITS-1:0] mask_high;
    logic [IDX_W-1:0]     word_index;
    logic                 row_present;
    logic                 last_word;
  } brrb_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] result_word;
    logic                 last_word_out;
  } brrb_out_t;

  // Per-word control shared by all lanes
  typedef struct packed {
    rop_t       op;
    logic [MODE_W-1:0] mode;
    logic       present;
    logic [OFF_W-1:0]  off;
  } brrb_ctl_t;

endpackage

// ===== sv/bit_row_raster_blit.sv =====
// ----------------------------------------------------------------------------
// bit_row_raster_blit
// Raster-op blit of one packed 32-bit word of a bit-image row per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; a beat is taken at each clock
//   edge with start high and busy low. busy never rises, so a new word may be
//   offered on every cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0 raster_op, 1 bit_shift, 2 dest_row_bits,
//   3 mask_row_bits, 4 boundary_mode; other indexes are dropped. Write only
//   while no word is in flight.
//   Result channel: result_valid pulses for one cycle with result, in the cycle
//   after the input beat. The receiver cannot stall; every result is taken.
//   Throughput: one word per cycle. The merge register is the only stage;
//   the 32 lanes are combinational behind it.
//   Reset (rst, synchronous): registers return to op set, shift 0, row
//   lengths 4096, boundary keep; no result is pending.
// ----------------------------------------------------------------------------
module bit_row_raster_blit #(
  parameter int MAX_ROW_BITS = brrb_pkg::DEF_MAX_ROW_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // input beat
  input  logic                              start,
  output logic                              busy,
  input  brrb_pkg::brrb_in_t                item,
  // config writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brrb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // result beat
  output logic                              result_valid,
  output brrb_pkg::brrb_out_t               result
);

  // Width that holds MAX_ROW_BITS and any row-length register value
  localparam int CLW  = $clog2(MAX_ROW_BITS + 1);
  localparam int SATW = (CLW > brrb_pkg::ROWLEN_W) ? CLW : brrb_pkg::ROWLEN_W;
  // Signed width for source bit positions (word pos minus shift plus lane)
  localparam int PW   = SATW + 3;
  localparam logic [SATW-1:0] MAX_LIM = SATW'(MAX_ROW_BITS);

  // Config registers
  brrb_pkg::rop_t                     raster_op;
  logic signed [brrb_pkg::SHIFT_W-1:0] bit_shift;
  logic [brrb_pkg::ROWLEN_W-1:0]      dest_row_bits;
  logic [brrb_pkg::ROWLEN_W-1:0]      mask_row_bits;
  logic [brrb_pkg::MODE_W-1:0]        boundary_mode;

  logic                               take;
  logic [SATW-1:0]                    dest_ext;
  logic [SATW-1:0]                    mask_ext;
  logic [SATW-1:0]                    dest_lim;
  logic [SATW-1:0]                    mask_lim;
  logic signed [PW-1:0]               word_pos;
  logic signed [PW-1:0]               shift_ext;
  logic signed [PW-1:0]               pos_base;
  brrb_pkg::brrb_ctl_t                ctl;
  logic [2*brrb_pkg::WORD_BITS-1:0]   pair;
  logic [brrb_pkg::WORD_BITS-1:0]     lane_bits;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_op     <= brrb_pkg::ROP_SET;
      bit_shift     <= '0;
      dest_row_bits <= brrb_pkg::RST_ROW_BITS;
      mask_row_bits <= brrb_pkg::RST_ROW_BITS;
      boundary_mode <= brrb_pkg::BND_KEEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        brrb_pkg::CFG_RASTER_OP:
          raster_op <= brrb_pkg::rop_t'(cfg_data[brrb_pkg::ROP_W-1:0]);
        brrb_pkg::CFG_BIT_SHIFT:
          bit_shift <= $signed(cfg_data[brrb_pkg::SHIFT_W-1:0]);
        brrb_pkg::CFG_DEST_ROW_BITS:
          dest_row_bits <= cfg_data[brrb_pkg::ROWLEN_W-1:0];
        brrb_pkg::CFG_MASK_ROW_BITS:
          mask_row_bits <= cfg_data[brrb_pkg::ROWLEN_W-1:0];
        brrb_pkg::CFG_BOUNDARY_MODE:
          boundary_mode <= cfg_data[brrb_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Row lengths saturate at MAX_ROW_BITS
  assign dest_ext = {{(SATW-brrb_pkg::ROWLEN_W){1'b0}}, dest_row_bits};
  assign mask_ext = {{(SATW-brrb_pkg::ROWLEN_W){1'b0}}, mask_row_bits};
  assign dest_lim = (dest_ext > MAX_LIM) ? MAX_LIM : dest_ext;
  assign mask_lim = (mask_ext > MAX_LIM) ? MAX_LIM : mask_ext;

  // Source position of lane 0; its low bits pick the window in the mask pair
  assign word_pos  = $signed({{(PW-brrb_pkg::GPOS_W){1'b0}}, item.word_index,
                              {brrb_pkg::OFF_W{1'b0}}});
  assign shift_ext = {{(PW-brrb_pkg::SHIFT_W){bit_shift[brrb_pkg::SHIFT_W-1]}},
                      bit_shift};
  assign pos_base  = word_pos - shift_ext;

  assign ctl.op      = raster_op;
  assign ctl.mode    = boundary_mode;
  assign ctl.present = item.row_present;
  assign ctl.off     = pos_base[brrb_pkg::OFF_W-1:0];

  assign pair = {item.mask_high, item.mask_low};

  // One lane per destination bit
  for (genvar i = 0; i < brrb_pkg::WORD_BITS; i++) begin : g_lane
    brrb_lane #(
      .LANE (i),
      .SATW (SATW),
      .PW   (PW)
    ) u_lane (
      .ctl        (ctl),
      .word_index (item.word_index),
      .pos_base   (pos_base),
      .dest_lim   (dest_lim),
      .mask_lim   (mask_lim),
      .pair       (pair),
      .d          (item.dest_word[i]),
      .r          (lane_bits[i])
    );
  end

  brrb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .lane_bits    (lane_bits),
    .last_word    (item.last_word),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== sv/brrb_lane.sv =====
// ----------------------------------------------------------------------------
// brrb_lane
// One bit lane: row and source coverage, mask pick, raster op, boundary fill.
// ----------------------------------------------------------------------------
module brrb_lane #(
  parameter int LANE = 0,
  parameter int SATW = 13,
  parameter int PW   = 16
) (
  input  brrb_pkg::brrb_ctl_t                   ctl,
  input  logic [brrb_pkg::IDX_W-1:0]            word_index,
  input  logic signed [PW-1:0]                  pos_base,
  input  logic [SATW-1:0]                       dest_lim,
  input  logic [SATW-1:0]                       mask_lim,
  input  logic [2*brrb_pkg::WORD_BITS-1:0]      pair,
  input  logic                                  d,
  output logic                                  r
);

  logic [brrb_pkg::GPOS_W-1:0] g;
  logic signed [PW-1:0]        m;
  logic [brrb_pkg::SEL_W-1:0]  sel;
  logic                        mb;
  logic                        in_row;
  logic                        covered;
  logic                        op_res;

  assign g       = {word_index, brrb_pkg::OFF_W'(LANE)};
  assign m       = pos_base + PW'(LANE);
  assign sel     = {1'b0, ctl.off} + brrb_pkg::SEL_W'(LANE);
  assign mb      = pair[sel];
  assign in_row  = {{(SATW-brrb_pkg::GPOS_W){1'b0}}, g} < dest_lim;
  assign covered = ctl.present && !m[PW-1] &&
                   (m < $signed({{(PW-SATW){1'b0}}, mask_lim}));

  always_comb begin
    case (ctl.op)
      brrb_pkg::ROP_SET:    op_res = mb;
      brrb_pkg::ROP_SETNOT: op_res = ~mb;
      brrb_pkg::ROP_AND:    op_res = d & mb;
      brrb_pkg::ROP_OR:     op_res = d | mb;
      brrb_pkg::ROP_ANDNOT: op_res = d & ~mb;
      brrb_pkg::ROP_ORNOT:  op_res = d | ~mb;
      default:              op_res = d;
    endcase
  end

  always_comb begin
    r = d;
    if (in_row) begin
      if (covered) begin
        r = op_res;
      end else begin
        case (ctl.mode)
          brrb_pkg::BND_CLEAR: r = 1'b0;
          brrb_pkg::BND_SET:   r = 1'b1;
          default:             r = d;
        endcase
      end
    end
  end

endmodule

// ===== sv/brrb_merge.sv =====
// ----------------------------------------------------------------------------
// brrb_merge
// Gathers the lane bits into the result word and drives the result strobe.
// ----------------------------------------------------------------------------
module brrb_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [brrb_pkg::WORD_BITS-1:0]  lane_bits,
  input  logic                            last_word,
  output logic                            result_valid,
  output brrb_pkg::brrb_out_t             result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.result_word   <= lane_bits;
      result.last_word_out <= last_word;
    end
  end

endmodule
